// ===== design/iirl_pkg.sv =====
// Shared constants, codes and cell control types for the insert/remove list unit
package iirl_pkg;

  localparam int DEPTH        = 128;
  localparam int KEY_BITS     = 16;
  localparam int PAYLOAD_BITS = 16;
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int ACT_W        = 4;
  localparam int STAT_W       = 3;

  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 4'd0;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 4'd1;
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 4'd2;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 4'd3;
  localparam logic [ACT_W-1:0] ACT_INSERT     = 4'd4;
  localparam logic [ACT_W-1:0] ACT_REMOVE     = 4'd5;
  localparam logic [ACT_W-1:0] ACT_GET        = 4'd6;
  localparam logic [ACT_W-1:0] ACT_FIND       = 4'd7;
  localparam logic [ACT_W-1:0] ACT_CLEAR      = 4'd8;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_OPEN,
    CELL_CLOSE
  } cell_op_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t                op;
    logic [IDX_W-1:0]        at;
    logic                    find;
    logic [CNT_W-1:0]        count;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } cell_ctl_t;

endpackage

// ===== design/indexed_insert_remove_list_unit.sv =====
// Ordered key/payload list of up to DEPTH entries, built as a shifting row of cells.
// A request is latched at its accepting edge, then the states S_EVAL, S_PICK and S_DONE follow: every
// cell compares in parallel, the lowest matching cell is picked, then the row shifts and the result is
// registered. busy is high from the accepting edge and drops as done rises, so the next request can
// be accepted at the edge that ends the result cycle; no new request is taken while one is in flight,
// whatever the action.
// The result is shown for one cycle with done high and cannot be held off.
module indexed_insert_remove_list_unit import iirl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [ACT_W-1:0]        action,
  input  logic [IDX_W-1:0]        position,
  input  logic [KEY_BITS-1:0]     entry_key,
  input  logic [PAYLOAD_BITS-1:0] entry_payload,
  output logic                    done,
  output logic [STAT_W-1:0]       status,
  output logic [KEY_BITS-1:0]     found_key,
  output logic [PAYLOAD_BITS-1:0] found_payload,
  output logic [IDX_W-1:0]        found_position,
  output logic [CNT_W-1:0]        entry_count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_PICK,
    S_DONE
  } state_t;

  state_t                  state;
  logic [ACT_W-1:0]        act;
  logic [IDX_W-1:0]        pos;
  logic [KEY_BITS-1:0]     req_key;
  logic [PAYLOAD_BITS-1:0] req_pay;
  logic [CNT_W-1:0]        count;

  logic [KEY_BITS-1:0]     cell_key [DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_pay [DEPTH];
  logic [DEPTH-1:0]        hits;

  logic                    pick_any;
  logic [KEY_BITS-1:0]     pick_key;
  logic [PAYLOAD_BITS-1:0] pick_pay;
  logic [IDX_W-1:0]        pick_index;
  logic                    hit_any;
  logic [KEY_BITS-1:0]     hit_key;
  logic [PAYLOAD_BITS-1:0] hit_pay;
  logic [IDX_W-1:0]        hit_index;

  cell_ctl_t               ctl;
  logic [CNT_W-1:0]        at_ext;
  logic [STAT_W-1:0]       status_next;
  logic [KEY_BITS-1:0]     key_next;
  logic [PAYLOAD_BITS-1:0] pay_next;
  logic [IDX_W-1:0]        index_next;
  logic [CNT_W-1:0]        count_next;
  cell_op_t                op_next;

  assign busy = (state != S_IDLE);

  // target position of the request
  always_comb begin
    case (act)
      ACT_PUSH_BACK:  at_ext = count;
      ACT_PUSH_FRONT: at_ext = '0;
      ACT_POP_BACK:   at_ext = count - CNT_W'(1);
      ACT_POP_FRONT:  at_ext = '0;
      default:        at_ext = {1'b0, pos};
    endcase
  end

  // outcome of the request, valid once the pick is registered
  always_comb begin
    status_next = ST_OK;
    key_next    = '0;
    pay_next    = '0;
    index_next  = '0;
    count_next  = count;
    op_next     = CELL_HOLD;
    case (act)
      ACT_PUSH_BACK, ACT_PUSH_FRONT, ACT_INSERT: begin
        if (at_ext > count) begin
          status_next = ST_RANGE;
        end else if (count >= CNT_W'(DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          op_next    = CELL_OPEN;
          count_next = count + CNT_W'(1);
          key_next   = req_key;
          pay_next   = req_pay;
        end
      end
      ACT_POP_BACK, ACT_POP_FRONT, ACT_REMOVE: begin
        if (act != ACT_REMOVE && count == '0) begin
          status_next = ST_EMPTY;
        end else if (at_ext >= count) begin
          status_next = ST_RANGE;
        end else begin
          op_next    = CELL_CLOSE;
          count_next = count - CNT_W'(1);
          key_next   = hit_key;
          pay_next   = hit_pay;
        end
      end
      ACT_GET: begin
        if (at_ext >= count) begin
          status_next = ST_RANGE;
        end else begin
          key_next = hit_key;
          pay_next = hit_pay;
        end
      end
      ACT_FIND: begin
        if (hit_any) begin
          key_next   = hit_key;
          pay_next   = hit_pay;
          index_next = hit_index;
        end else begin
          status_next = ST_NOTFOUND;
        end
      end
      ACT_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctl.op      = (state == S_DONE) ? op_next : CELL_HOLD;
    ctl.at      = at_ext[IDX_W-1:0];
    ctl.find    = (act == ACT_FIND);
    ctl.count   = count;
    ctl.key     = req_key;
    ctl.payload = req_pay;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0]     lk, rk;
    logic [PAYLOAD_BITS-1:0] lp, rp;
    if (i == 0) begin : g_first
      assign lk = '0;
      assign lp = '0;
    end else begin : g_left
      assign lk = cell_key[i-1];
      assign lp = cell_pay[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rk = '0;
      assign rp = '0;
    end else begin : g_right
      assign rk = cell_key[i+1];
      assign rp = cell_pay[i+1];
    end
    iirl_cell u_cell (
      .clk           (clk),
      .cell_index    (IDX_W'(i)),
      .ctl           (ctl),
      .left_key      (lk),
      .left_payload  (lp),
      .right_key     (rk),
      .right_payload (rp),
      .key           (cell_key[i]),
      .payload       (cell_pay[i]),
      .hit           (hits[i])
    );
  end

  iirl_select u_select (
    .hits        (hits),
    .keys        (cell_key),
    .payloads    (cell_pay),
    .any         (pick_any),
    .sel_key     (pick_key),
    .sel_payload (pick_pay),
    .sel_index   (pick_index)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            act     <= action;
            pos     <= position;
            req_key <= entry_key;
            req_pay <= entry_payload;
            state   <= S_EVAL;
          end
        end
        S_EVAL: begin
          state <= S_PICK;
        end
        S_PICK: begin
          hit_any   <= pick_any;
          hit_key   <= pick_key;
          hit_pay   <= pick_pay;
          hit_index <= pick_index;
          state     <= S_DONE;
        end
        S_DONE: begin
          count          <= count_next;
          done           <= 1'b1;
          status         <= status_next;
          found_key      <= key_next;
          found_payload  <= pay_next;
          found_position <= index_next;
          entry_count    <= count_next;
          state          <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_after_shift: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_DONE))
    else $error("result strobe without a completed request");

  a_count_shown: assert property (@(posedge clk) disable iff (rst)
    done |-> (entry_count == count))
    else $error("reported count differs from held count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (count <= CNT_W'(DEPTH)))
    else $error("entry count beyond capacity");

  a_find_key: assert property (@(posedge clk) disable iff (rst)
    (done && act == ACT_FIND && status == ST_OK) |-> (found_key == req_key))
    else $error("find returned an entry with a different key");

endmodule

// ===== design/iirl_cell.sv =====
// One list cell: holds an entry, shifts with its neighbours and flags a match
module iirl_cell import iirl_pkg::*; (
  input  logic                    clk,
  input  logic [IDX_W-1:0]        cell_index,
  input  cell_ctl_t               ctl,
  input  logic [KEY_BITS-1:0]     left_key,
  input  logic [PAYLOAD_BITS-1:0] left_payload,
  input  logic [KEY_BITS-1:0]     right_key,
  input  logic [PAYLOAD_BITS-1:0] right_payload,
  output logic [KEY_BITS-1:0]     key,
  output logic [PAYLOAD_BITS-1:0] payload,
  output logic                    hit
);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_OPEN: begin
        if (cell_index > ctl.at) begin
          key     <= left_key;
          payload <= left_payload;
        end else if (cell_index == ctl.at) begin
          key     <= ctl.key;
          payload <= ctl.payload;
        end
      end
      CELL_CLOSE: begin
        if (cell_index >= ctl.at) begin
          key     <= right_key;
          payload <= right_payload;
        end
      end
      default: begin
      end
    endcase

    // find: key match among live entries; otherwise the addressed cell
    if (ctl.find) begin
      hit <= (key == ctl.key) && ({1'b0, cell_index} < ctl.count);
    end else begin
      hit <= (cell_index == ctl.at);
    end
  end

endmodule

// ===== design/iirl_select.sv =====
// Lowest-hit pick across the cell row: returns the chosen entry and its index
module iirl_select import iirl_pkg::*; (
  input  logic [DEPTH-1:0]        hits,
  input  logic [KEY_BITS-1:0]     keys     [DEPTH],
  input  logic [PAYLOAD_BITS-1:0] payloads [DEPTH],
  output logic                    any,
  output logic [KEY_BITS-1:0]     sel_key,
  output logic [PAYLOAD_BITS-1:0] sel_payload,
  output logic [IDX_W-1:0]        sel_index
);

  logic [DEPTH-1:0] lowest;

  // isolate the lowest set bit
  assign lowest = hits & (~hits + DEPTH'(1));
  assign any    = |hits;

  always_comb begin
    sel_key     = '0;
    sel_payload = '0;
    sel_index   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (lowest[i]) begin
        sel_key     = sel_key | keys[i];
        sel_payload = sel_payload | payloads[i];
        sel_index   = sel_index | IDX_W'(i);
      end
    end
  end

endmodule

// ===== verif/indexed_insert_remove_list_unit_test.sv =====
// Self-checking test of the insert/remove list unit: directed table, then random traffic
`timescale 1ns / 1ps

module indexed_insert_remove_list_unit_test;
  import iirl_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 4'd9;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 4'd15;
  localparam int DIRECTED_ROWS  = 25;
  localparam int RANDOM_REQUESTS = 1800;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [IDX_W-1:0]        position;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } list_request_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [IDX_W-1:0]        position;
    logic [CNT_W-1:0]        count;
  } list_result_t;

  typedef struct packed {
    list_request_t req;
    logic          typed;
    list_result_t  want;
  } directed_row_t;

  typedef enum logic [1:0] {
    MIX_GROW,
    MIX_SHRINK,
    MIX_BALANCED
  } traffic_mode_t;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [ACT_W-1:0]        action;
  logic [IDX_W-1:0]        position;
  logic [KEY_BITS-1:0]     entry_key;
  logic [PAYLOAD_BITS-1:0] entry_payload;
  logic                    done;
  logic [STAT_W-1:0]       status;
  logic [KEY_BITS-1:0]     found_key;
  logic [PAYLOAD_BITS-1:0] found_payload;
  logic [IDX_W-1:0]        found_position;
  logic [CNT_W-1:0]        entry_count;

  // Shadow copy of the list, advanced at each accepted request
  logic [KEY_BITS-1:0]     list_keys [DEPTH];
  logic [PAYLOAD_BITS-1:0] list_payloads [DEPTH];
  int                      list_len;

  list_result_t expected_results [$];
  int           fail_count;

  // Expectations are typed in only where they can be read off directly
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{ACT_POP_BACK,   7'd0,   16'h0000, 16'h0000}, 1'b1,
      '{ST_EMPTY,    16'h0000, 16'h0000, 7'd0, 8'd0}},
    '{'{ACT_POP_FRONT,  7'd0,   16'h0000, 16'h0000}, 1'b1,
      '{ST_EMPTY,    16'h0000, 16'h0000, 7'd0, 8'd0}},
    '{'{ACT_REMOVE,     7'd0,   16'h0000, 16'h0000}, 1'b1,
      '{ST_RANGE,    16'h0000, 16'h0000, 7'd0, 8'd0}},
    '{'{ACT_GET,        7'd127, 16'h0000, 16'h0000}, 1'b1,
      '{ST_RANGE,    16'h0000, 16'h0000, 7'd0, 8'd0}},
    '{'{ACT_FIND,       7'd0,   16'hFFFF, 16'h0000}, 1'b1,
      '{ST_NOTFOUND, 16'h0000, 16'h0000, 7'd0, 8'd0}},
    '{'{ACT_INSERT,     7'd1,   16'h1111, 16'h2222}, 1'b1,
      '{ST_RANGE,    16'h0000, 16'h0000, 7'd0, 8'd0}},
    '{'{ACT_INSERT,     7'd0,   16'hFFFF, 16'h0000}, 1'b1,
      '{ST_OK,       16'hFFFF, 16'h0000, 7'd0, 8'd1}},
    '{'{ACT_PUSH_BACK,  7'd0,   16'h0000, 16'hFFFF}, 1'b1,
      '{ST_OK,       16'h0000, 16'hFFFF, 7'd0, 8'd2}},
    '{'{ACT_PUSH_FRONT, 7'd0,   16'h1234, 16'h5678}, 1'b1,
      '{ST_OK,       16'h1234, 16'h5678, 7'd0, 8'd3}},
    '{'{ACT_INSERT,     7'd3,   16'hFFFF, 16'h5555}, 1'b0, '0},
    '{'{ACT_FIND,       7'd0,   16'hFFFF, 16'h0000}, 1'b0, '0},
    '{'{ACT_GET,        7'd3,   16'h0000, 16'h0000}, 1'b0, '0},
    '{'{ACT_REMOVE,     7'd1,   16'h0000, 16'h0000}, 1'b0, '0},
    '{'{ACT_GET,        7'd127, 16'h0000, 16'h0000}, 1'b1,
      '{ST_RANGE,    16'h0000, 16'h0000, 7'd0, 8'd3}},
    '{'{ACT_REMOVE,     7'd127, 16'h0000, 16'h0000}, 1'b1,
      '{ST_RANGE,    16'h0000, 16'h0000, 7'd0, 8'd3}},
    '{'{ACT_INSERT,     7'd127, 16'hAAAA, 16'hAAAA}, 1'b1,
      '{ST_RANGE,    16'h0000, 16'h0000, 7'd0, 8'd3}},
    '{'{ACT_FIND,       7'd0,   16'h0000, 16'h0000}, 1'b0, '0},
    '{'{ACT_POP_BACK,   7'd0,   16'h0000, 16'h0000}, 1'b0, '0},
    '{'{ACT_POP_FRONT,  7'd0,   16'h0000, 16'h0000}, 1'b0, '0},
    '{'{ACT_UNUSED_LO,  7'd127, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
    '{'{ACT_UNUSED_HI,  7'd0,   16'h0000, 16'h0000}, 1'b0, '0},
    '{'{ACT_CLEAR,      7'd55,  16'h0000, 16'h0000}, 1'b1,
      '{ST_OK,       16'h0000, 16'h0000, 7'd0, 8'd0}},
    '{'{ACT_FIND,       7'd0,   16'h1234, 16'h0000}, 1'b1,
      '{ST_NOTFOUND, 16'h0000, 16'h0000, 7'd0, 8'd0}},
    '{'{ACT_PUSH_FRONT, 7'd0,   16'hAAAA, 16'h5555}, 1'b0, '0},
    '{'{ACT_POP_FRONT,  7'd0,   16'h0000, 16'h0000}, 1'b0, '0}
  };

  indexed_insert_remove_list_unit dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .position       (position),
    .entry_key      (entry_key),
    .entry_payload  (entry_payload),
    .done           (done),
    .status         (status),
    .found_key      (found_key),
    .found_payload  (found_payload),
    .found_position (found_position),
    .entry_count    (entry_count)
  );

  always #6 clk = ~clk;

  function automatic list_result_t list_apply(input list_request_t req);
    list_result_t r;
    int           at;
    int           i;
    r = '0;
    r.status = ST_OK;
    case (req.action)
      ACT_PUSH_BACK, ACT_PUSH_FRONT, ACT_INSERT: begin
        at = (req.action == ACT_PUSH_BACK) ? list_len :
             (req.action == ACT_PUSH_FRONT) ? 0 : int'(req.position);
        // range is judged before fullness
        if (at > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_len; i > at; i--) begin
            list_keys[i]     = list_keys[i-1];
            list_payloads[i] = list_payloads[i-1];
          end
          list_keys[at]     = req.key;
          list_payloads[at] = req.payload;
          list_len++;
          r.key     = req.key;
          r.payload = req.payload;
        end
      end
      ACT_POP_BACK, ACT_POP_FRONT, ACT_REMOVE: begin
        if (req.action != ACT_REMOVE && list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          at = (req.action == ACT_POP_BACK) ? list_len - 1 :
               (req.action == ACT_POP_FRONT) ? 0 : int'(req.position);
          if (at >= list_len) begin
            r.status = ST_RANGE;
          end else begin
            r.key     = list_keys[at];
            r.payload = list_payloads[at];
            for (i = at; i + 1 < list_len; i++) begin
              list_keys[i]     = list_keys[i+1];
              list_payloads[i] = list_payloads[i+1];
            end
            list_len--;
          end
        end
      end
      ACT_GET: begin
        if (int'(req.position) >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.key     = list_keys[req.position];
          r.payload = list_payloads[req.position];
        end
      end
      ACT_FIND: begin
        r.status = ST_NOTFOUND;
        // lowest index wins
        for (i = 0; i < list_len; i++) begin
          if (r.status == ST_NOTFOUND && list_keys[i] == req.key) begin
            r.status   = ST_OK;
            r.key      = list_keys[i];
            r.payload  = list_payloads[i];
            r.position = IDX_W'(i);
          end
        end
      end
      ACT_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(list_len);
    return r;
  endfunction

  function automatic list_request_t pick_request(input traffic_mode_t mode);
    list_request_t req;
    int            roll;
    int            reach;
    roll = $urandom_range(0, 99);
    case (mode)
      MIX_GROW: begin
        req.action = (roll < 30) ? ACT_PUSH_BACK :
                     (roll < 50) ? ACT_PUSH_FRONT :
                     (roll < 80) ? ACT_INSERT :
                     (roll < 85) ? ACT_POP_BACK :
                     (roll < 90) ? ACT_REMOVE :
                     (roll < 95) ? ACT_FIND : ACT_GET;
      end
      MIX_SHRINK: begin
        req.action = (roll < 25) ? ACT_POP_BACK :
                     (roll < 45) ? ACT_POP_FRONT :
                     (roll < 75) ? ACT_REMOVE :
                     (roll < 82) ? ACT_INSERT :
                     (roll < 86) ? ACT_PUSH_BACK :
                     (roll < 93) ? ACT_FIND : ACT_GET;
      end
      default: begin
        if (roll < 2) begin
          req.action = ACT_CLEAR;
        end else if (roll < 5) begin
          req.action = ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        end else begin
          req.action = ACT_W'($urandom_range(ACT_PUSH_BACK, ACT_FIND));
        end
      end
    endcase
    // keep most positions near the filled part, where the shifts happen
    reach = (list_len > DEPTH - 1) ? DEPTH - 1 : list_len;
    if ($urandom_range(0, 3) != 0) begin
      req.position = IDX_W'($urandom_range(0, reach));
    end else begin
      req.position = IDX_W'($urandom_range(0, DEPTH - 1));
    end
    // narrow keys give duplicates, so find must pick the lowest index
    roll = $urandom_range(0, 99);
    if (req.action == ACT_FIND && list_len > 0 && roll < 60) begin
      req.key = list_keys[$urandom_range(0, list_len - 1)];
    end else if (roll < 50) begin
      req.key = KEY_BITS'($urandom_range(0, 7));
    end else if (roll < 55) begin
      req.key = '1;
    end else begin
      req.key = KEY_BITS'($urandom());
    end
    req.payload = PAYLOAD_BITS'($urandom());
    return req;
  endfunction

  function automatic int idle_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Present a request, hold it until accepted, then record its expectation
  task automatic send_request(input list_request_t req, input logic typed,
                              input list_result_t want);
    list_result_t predicted;
    action        = req.action;
    position      = req.position;
    entry_key     = req.key;
    entry_payload = req.payload;
    start         = 1'b1;
    do @(posedge clk); while (busy);
    predicted = list_apply(req);
    expected_results.insert(expected_results.size(), typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic pause_requests(input int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: status %0d", status);
        fail_count++;
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        compare_field("status",         32'(want.status),   32'(status));
        compare_field("found_key",      32'(want.key),      32'(found_key));
        compare_field("found_payload",  32'(want.payload),  32'(found_payload));
        compare_field("found_position", 32'(want.position), 32'(found_position));
        compare_field("entry_count",    32'(want.count),    32'(entry_count));
      end
    end
  end

  initial begin : stimulus
    list_request_t req;
    traffic_mode_t mode;
    int            row;
    int            sent;
    int            burst;
    int            burst_index;
    int            waited;
    logic          quiet;
    clk           = 1'b0;
    rst           = 1'b1;
    start         = 1'b0;
    action        = ACT_PUSH_BACK;
    position      = '0;
    entry_key     = '0;
    entry_payload = '0;
    list_len      = 0;
    fail_count    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (row = 0; row < DIRECTED_ROWS; row++) begin
      send_request(directed_rows[row].req, directed_rows[row].typed,
                   directed_rows[row].want);
      pause_requests(idle_cycles());
    end

    // fill to the brim first, then drain to empty, then mix freely
    sent        = 0;
    burst_index = 0;
    while (sent < RANDOM_REQUESTS) begin
      if (burst_index == 0) begin
        mode = MIX_GROW;
      end else if (burst_index == 1) begin
        mode = MIX_SHRINK;
      end else begin
        mode = traffic_mode_t'($urandom_range(MIX_GROW, MIX_BALANCED));
      end
      burst = (burst_index < 2) ? 260 :
              (mode == MIX_GROW) ? $urandom_range(160, 260) : $urandom_range(40, 200);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (burst) begin
        req = pick_request(mode);
        send_request(req, 1'b0, '0);
        sent++;
        if (!quiet) pause_requests(idle_cycles());
      end
      burst_index++;
    end
    start = 1'b0;

    for (waited = 0; waited < 200 && expected_results.size() != 0; waited++)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d requests left without a result", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/iirl_pkg.sv
design/iirl_cell.sv
design/iirl_select.sv
design/indexed_insert_remove_list_unit.sv
verif/indexed_insert_remove_list_unit_test.sv
